// ===== hw/rtl/clcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Character LCD write sequencer package
// Shared types, constants and the init command table.
// ----------------------------------------------------------------------------
package clcd_pkg;

	localparam int COUNT_WIDTH = 20;
	localparam int QUEUE_DEPTH = 4;
	localparam int INIT_COUNT  = 5;
	localparam int CFG_DATA_W  = 20;

	typedef enum logic [1:0] {
		CFG_ENABLE_HIGH = 2'd0,
		CFG_NIBBLE_GAP  = 2'd1,
		CFG_BYTE_GAP    = 2'd2,
		CFG_POWER_ON    = 2'd3
	} clcd_cfg_idx_t;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
		logic       register_select;
	} clcd_in_t;

	typedef struct packed {
		logic [3:0] lcd_data_nibble;
		logic       lcd_rs;
		logic       lcd_enable;
		logic       busy_res;
		logic       accepted;
		logic       init_done;
	} clcd_out_t;

	typedef struct packed {
		logic       is_write;
		logic [7:0] data_byte;
		logic       register_select;
	} clcd_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} clcd_qstat_t;

	typedef struct packed {
		logic                  valid;
		clcd_cfg_idx_t         index;
		logic [CFG_DATA_W-1:0] data;
	} clcd_cfg_wr_t;

	function automatic logic [7:0] init_cmd(input logic [2:0] step);
		logic [7:0] cmd;
		case (step)
			3'd0:    cmd = 8'h02;
			3'd1:    cmd = 8'h28;
			3'd2:    cmd = 8'h0C;
			3'd3:    cmd = 8'h06;
			3'd4:    cmd = 8'h01;
			default: cmd = 8'h00;
		endcase
		return cmd;
	endfunction

endpackage

// ===== hw/rtl/clcd_front.sv =====
// ----------------------------------------------------------------------------
// Front stage
// Accepts input items, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module clcd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  clcd_pkg::clcd_in_t   req,
	input  clcd_pkg::clcd_qstat_t qstat,
	output logic                 push,
	output clcd_pkg::clcd_cmd_t  push_cmd
);
	import clcd_pkg::*;

	logic      valid_s1;
	clcd_cmd_t cmd_s1;

	assign req_stall = valid_s1 & qstat.full;
	assign push      = valid_s1 & ~qstat.full;
	assign push_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			cmd_s1.is_write        <= req.operation;
			cmd_s1.data_byte       <= req.data_byte;
			cmd_s1.register_select <= req.register_select;
		end
	end

endmodule

// ===== hw/rtl/clcd_queue.sv =====
// ----------------------------------------------------------------------------
// Item queue
// Short first-in first-out queue between the front and back stages.
// ----------------------------------------------------------------------------
module clcd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  clcd_pkg::clcd_cmd_t   push_cmd,
	input  logic                  pop,
	output clcd_pkg::clcd_cmd_t   head,
	output clcd_pkg::clcd_qstat_t qstat
);
	import clcd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	clcd_cmd_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push & ~qstat.full;
	assign do_pop      = pop & ~qstat.empty;
	assign head        = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== hw/rtl/clcd_back.sv =====
// ----------------------------------------------------------------------------
// Back stage
// Runs the power-on wait, init sequence and nibble timing, one item a cycle unless stalled.
// ----------------------------------------------------------------------------
module clcd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  clcd_pkg::clcd_cfg_wr_t cfg_wr,
	input  clcd_pkg::clcd_cmd_t   head,
	input  clcd_pkg::clcd_qstat_t qstat,
	output logic                  pop,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output clcd_pkg::clcd_out_t   rsp
);
	import clcd_pkg::*;

	localparam int LEN_W = (COUNT_WIDTH + 1 > 21) ? COUNT_WIDTH + 1 : 21;

	typedef enum logic [3:0] {
		PH_POWER  = 4'd0,
		PH_HI_EN  = 4'd1,
		PH_HI_GAP = 4'd2,
		PH_LO_EN  = 4'd3,
		PH_LO_GAP = 4'd4,
		PH_IDLE   = 4'd5
	} phase_t;

	logic [7:0]             enable_high_q;
	logic [15:0]            nibble_gap_q;
	logic [15:0]            byte_gap_q;
	logic [19:0]            power_on_q;

	phase_t                 phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] count_q, count_d;
	logic [7:0]             byte_q, byte_d;
	logic [2:0]             step_q, step_d;
	logic [3:0]             nibble_q, nibble_d;
	logic                   rs_q, rs_d;
	logic                   en_q, en_d;
	logic                   took;

	logic [19:0]            reg_sel;
	logic [LEN_W-1:0]       len;
	logic [LEN_W-1:0]       cnt_inc;
	logic                   done;
	logic [2:0]             step_inc;
	logic [7:0]             first_cmd;
	logic [7:0]             next_cmd;

	assign pop = ~qstat.empty & (~rsp_valid | ~rsp_stall);

	always_comb begin
		case (phase_q)
			PH_POWER:  reg_sel = power_on_q;
			PH_HI_EN:  reg_sel = 20'(enable_high_q);
			PH_HI_GAP: reg_sel = 20'(nibble_gap_q);
			PH_LO_EN:  reg_sel = 20'(enable_high_q);
			PH_LO_GAP: reg_sel = 20'(byte_gap_q);
			default:   reg_sel = '0;
		endcase
		len = LEN_W'(reg_sel);
		if (len == '0) begin
			len = LEN_W'(1);
		end
		if (len > (LEN_W'(1) << COUNT_WIDTH)) begin
			len = LEN_W'(1) << COUNT_WIDTH;
		end
		cnt_inc   = LEN_W'(count_q) + LEN_W'(1);
		done      = (cnt_inc >= len);
		step_inc  = step_q + 3'd1;
		first_cmd = init_cmd(3'd0);
		next_cmd  = init_cmd(step_inc);
	end

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		byte_d   = byte_q;
		step_d   = step_q;
		nibble_d = nibble_q;
		rs_d     = rs_q;
		en_d     = en_q;
		took     = 1'b0;
		if (head.is_write) begin
			if (phase_q == PH_IDLE) begin
				took     = 1'b1;
				byte_d   = head.data_byte;
				phase_d  = PH_HI_EN;
				count_d  = '0;
				nibble_d = head.data_byte[7:4];
				rs_d     = head.register_select;
				en_d     = 1'b1;
			end
		end else if (phase_q != PH_IDLE) begin
			if (!done) begin
				count_d = cnt_inc[COUNT_WIDTH-1:0];
			end else begin
				count_d = '0;
				case (phase_q)
					PH_POWER: begin
						step_d   = '0;
						byte_d   = first_cmd;
						phase_d  = PH_HI_EN;
						nibble_d = first_cmd[7:4];
						rs_d     = 1'b0;
						en_d     = 1'b1;
					end
					PH_HI_EN: begin
						phase_d = PH_HI_GAP;
						en_d    = 1'b0;
					end
					PH_HI_GAP: begin
						phase_d  = PH_LO_EN;
						nibble_d = byte_q[3:0];
						en_d     = 1'b1;
					end
					PH_LO_EN: begin
						phase_d = PH_LO_GAP;
						en_d    = 1'b0;
					end
					default: begin
						phase_d = PH_IDLE;
						if (step_q < 3'(INIT_COUNT)) begin
							step_d = step_inc;
							if (step_inc < 3'(INIT_COUNT)) begin
								byte_d   = next_cmd;
								phase_d  = PH_HI_EN;
								nibble_d = next_cmd[7:4];
								rs_d     = 1'b0;
								en_d     = 1'b1;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_high_q <= 8'd1;
			nibble_gap_q  <= 16'd200;
			byte_gap_q    <= 16'd2000;
			power_on_q    <= 20'd20000;
		end else if (cfg_wr.valid) begin
			case (cfg_wr.index)
				CFG_ENABLE_HIGH: enable_high_q <= cfg_wr.data[7:0];
				CFG_NIBBLE_GAP:  nibble_gap_q  <= cfg_wr.data[15:0];
				CFG_BYTE_GAP:    byte_gap_q    <= cfg_wr.data[15:0];
				CFG_POWER_ON:    power_on_q    <= cfg_wr.data[19:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_POWER;
			count_q   <= '0;
			byte_q    <= '0;
			step_q    <= '0;
			nibble_q  <= '0;
			rs_q      <= 1'b0;
			en_q      <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (pop) begin
				phase_q  <= phase_d;
				count_q  <= count_d;
				byte_q   <= byte_d;
				step_q   <= step_d;
				nibble_q <= nibble_d;
				rs_q     <= rs_d;
				en_q     <= en_d;
			end
			if (pop) begin
				rsp_valid <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rsp.lcd_data_nibble <= nibble_d;
			rsp.lcd_rs          <= rs_d;
			rsp.lcd_enable      <= en_d;
			rsp.busy_res        <= (phase_d != PH_IDLE);
			rsp.accepted        <= took;
			rsp.init_done       <= (step_d >= 3'(INIT_COUNT));
		end
	end

endmodule

// ===== hw/rtl/char_lcd_nibble_write_sequencer.sv =====
// ----------------------------------------------------------------------------
// Character LCD nibble write sequencer
// Drives a 4-bit character LCD bus from a stream of tick and write items.
// ----------------------------------------------------------------------------
// Each item on req is either one time tick or a write request with a byte and
// a register select. Every item yields exactly one result on rsp, giving the
// LCD pin levels, the busy flag, whether a write was taken and whether the
// init sequence has finished.
// The block takes one item per cycle when nothing stalls. An item passes a
// front register, a four-entry queue and the sequencer's output register
// on its way to the result.
// When the receiver raises rsp_stall the result holds; the queue keeps
// taking items until it fills, and then req_stall rises.
// After reset the block waits power_on_ticks ticks, then sends the init
// commands on its own; write requests made before that, or while a byte is
// still going out, are refused with accepted low.
// Configuration writes on cfg are always ready and take effect at once; they
// are meant to be made while no item is in flight.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  clcd_pkg::clcd_in_t                 req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output clcd_pkg::clcd_out_t                rsp,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  clcd_pkg::clcd_cfg_idx_t            cfg_index,
	input  logic [clcd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import clcd_pkg::*;

	clcd_qstat_t  qstat;
	clcd_cmd_t    push_cmd;
	clcd_cmd_t    head;
	clcd_cfg_wr_t cfg_wr;
	logic         push;
	logic         pop;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.valid = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	clcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.qstat     (qstat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	clcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	clcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== hw/rtl/clcd_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Assertions on the top level's ports, bound to the top level.
// ----------------------------------------------------------------------------
module clcd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input clcd_pkg::clcd_out_t rsp
);
	import clcd_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("Stalled result item changed.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.accepted |-> rsp.busy_res && rsp.lcd_enable)
		else $error("Taken write did not start a byte.");

	a_enable_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.lcd_enable |-> rsp.busy_res)
		else $error("Enable high while idle.");

	a_init_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.init_done |-> rsp.busy_res && !rsp.accepted)
		else $error("Idle or write taken before init finished.");

endmodule

bind char_lcd_nibble_write_sequencer clcd_checker u_clcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Character LCD nibble write sequencer testbench
// Feeds the block tick and write items in bursts with random gaps. The result
// side stalls on a pattern of its own, with one long hold-off that backs the
// block up. Every result is checked field by field against a cycle-free
// predictor of the power-on wait, the init commands and the nibble strobes.
// Timing registers are changed between phases, including while a phase of
// the sequencer is part way through.
// ----------------------------------------------------------------------------
module tb;
	import clcd_pkg::*;

	localparam int          CYCLE_LIMIT = 400000;
	localparam logic [39:0] INIT_BYTES  = 40'h02_28_0C_06_01;

	typedef enum logic [2:0] {
		SEQ_POWER,
		SEQ_HI_EN,
		SEQ_HI_GAP,
		SEQ_LO_EN,
		SEQ_LO_GAP,
		SEQ_IDLE
	} seq_phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	clcd_in_t              req = '0;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	clcd_out_t             rsp;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	clcd_cfg_idx_t         cfg_index = CFG_ENABLE_HIGH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor state and its copy of the timing registers.
	logic [7:0]  enable_len = 8'd1;
	logic [15:0] nibble_gap_len = 16'd200;
	logic [15:0] byte_gap_len = 16'd2000;
	logic [19:0] power_on_len = 20'd20000;
	seq_phase_t  seq_phase = SEQ_POWER;
	logic [19:0] phase_ticks = '0;
	logic [7:0]  held_byte = '0;
	logic        held_select = 1'b0;
	logic [2:0]  init_step = '0;
	logic [3:0]  pin_nibble = '0;
	logic        pin_rs = 1'b0;
	logic        pin_enable = 1'b0;

	clcd_in_t  pending_items[$];
	clcd_out_t expected_pins[$];
	clcd_out_t want;
	logic      req_taken = 1'b0;
	int        mismatch_count = 0;
	int        cycle_count = 0;
	int        burst_left = 1;
	int        gap_left = 0;
	int        stall_mode = 0;
	int        mode_left = 0;
	int        hold_left = 0;
	logic      squeeze_now = 1'b0;

	char_lcd_nibble_write_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic void launch_byte(input logic [7:0] b, input logic sel);
		held_byte   = b;
		held_select = sel;
		seq_phase   = SEQ_HI_EN;
		phase_ticks = '0;
		pin_nibble  = b[7:4];
		pin_rs      = sel;
		pin_enable  = 1'b1;
	endfunction

	function automatic void advance_tick();
		logic [31:0] span;
		case (seq_phase)
			SEQ_POWER:             span = 32'(power_on_len);
			SEQ_HI_EN, SEQ_LO_EN:  span = 32'(enable_len);
			SEQ_HI_GAP:            span = 32'(nibble_gap_len);
			SEQ_LO_GAP:            span = 32'(byte_gap_len);
			default:               return;
		endcase
		if (span == 0)
			span = 1;
		if (32'(phase_ticks) + 32'd1 < span) begin
			phase_ticks = phase_ticks + 20'd1;
			return;
		end
		phase_ticks = '0;
		case (seq_phase)
			SEQ_POWER: begin
				init_step = '0;
				launch_byte(INIT_BYTES[39 -: 8], 1'b0);
			end
			SEQ_HI_EN: begin
				seq_phase  = SEQ_HI_GAP;
				pin_enable = 1'b0;
			end
			SEQ_HI_GAP: begin
				seq_phase  = SEQ_LO_EN;
				pin_nibble = held_byte[3:0];
				pin_enable = 1'b1;
			end
			SEQ_LO_EN: begin
				seq_phase  = SEQ_LO_GAP;
				pin_enable = 1'b0;
			end
			default: begin
				if (init_step < INIT_COUNT) begin
					init_step = init_step + 3'd1;
					if (init_step < INIT_COUNT) begin
						launch_byte(INIT_BYTES[39 - 8 * init_step -: 8], 1'b0);
						return;
					end
				end
				seq_phase = SEQ_IDLE;
			end
		endcase
	endfunction

	function automatic clcd_out_t lcd_pins_after(input clcd_in_t it);
		clcd_out_t o;
		logic      took;
		took = 1'b0;
		if (it.operation) begin
			if (seq_phase == SEQ_IDLE) begin
				launch_byte(it.data_byte, it.register_select);
				took = 1'b1;
			end
		end else begin
			advance_tick();
		end
		o.lcd_data_nibble = pin_nibble;
		o.lcd_rs          = pin_rs;
		o.lcd_enable      = pin_enable;
		o.busy_res        = (seq_phase != SEQ_IDLE);
		o.accepted        = took;
		o.init_done       = (init_step >= INIT_COUNT);
		return o;
	endfunction

	task automatic check_field(input string field, input int unsigned exp_v, got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	// Sender: holds a stalled item, otherwise works through bursts and gaps.
	always @(negedge clk) begin
		if (arst_n && !(req_valid && !req_taken)) begin
			if (gap_left != 0) begin
				gap_left  <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				req       <= pending_items.pop_front();
				req_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 48);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver: modes of no stall, heavy stall and light stall, plus a long hold-off.
	always @(negedge clk) begin
		if (squeeze_now) begin
			squeeze_now = 1'b0;
			hold_left   = 80;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left  = $urandom_range(10, 60);
			end else begin
				mode_left = mode_left - 1;
			end
			case (stall_mode)
				0:       rsp_stall <= 1'b0;
				1:       rsp_stall <= 1'($urandom_range(0, 1));
				default: rsp_stall <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		req_taken = req_valid && !req_stall;
		if (arst_n) begin
			cycle_count++;
			if (req_taken)
				expected_pins.push_back(lcd_pins_after(req));
			if (rsp_valid && !rsp_stall) begin
				if (expected_pins.size() == 0) begin
					$display("%0t: result %h arrived with nothing expected", $time, rsp);
					mismatch_count++;
				end else begin
					want = expected_pins.pop_front();
					check_field("lcd_data_nibble", want.lcd_data_nibble, rsp.lcd_data_nibble);
					check_field("lcd_rs", want.lcd_rs, rsp.lcd_rs);
					check_field("lcd_enable", want.lcd_enable, rsp.lcd_enable);
					check_field("busy_res", want.busy_res, rsp.busy_res);
					check_field("accepted", want.accepted, rsp.accepted);
					check_field("init_done", want.init_done, rsp.init_done);
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	task automatic push_ticks(input int n);
		clcd_in_t it;
		it = '0;
		repeat (n)
			pending_items.push_back(it);
	endtask

	task automatic push_write(input logic [7:0] b, input logic sel);
		clcd_in_t it;
		it.operation       = 1'b1;
		it.data_byte       = b;
		it.register_select = sel;
		pending_items.push_back(it);
	endtask

	task automatic push_random(input int n, input int write_pct);
		clcd_in_t it;
		repeat (n) begin
			it.operation       = ($urandom_range(0, 99) < write_pct);
			it.data_byte       = 8'($urandom);
			it.register_select = 1'($urandom_range(0, 1));
			pending_items.push_back(it);
		end
	endtask

	// Waits until every item has been taken and answered, then lets the pipeline drain.
	task automatic settle();
		while (pending_items.size() != 0 || req_valid || expected_pins.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_timing(input clcd_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_ENABLE_HIGH: enable_len = val[7:0];
			CFG_NIBBLE_GAP:  nibble_gap_len = val[15:0];
			CFG_BYTE_GAP:    byte_gap_len = val[15:0];
			default:         power_on_len = val[19:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int en, nib, gap, n, write_pct);
		settle();
		write_timing(CFG_ENABLE_HIGH, CFG_DATA_W'(en));
		write_timing(CFG_NIBBLE_GAP, CFG_DATA_W'(nib));
		write_timing(CFG_BYTE_GAP, CFG_DATA_W'(gap));
		push_random(n, write_pct);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Power-on wait under the reset timing: requests are refused.
		push_ticks(1);
		push_write(8'hA5, 1'b1);
		push_ticks(2);
		settle();
		write_timing(CFG_POWER_ON, 20'hFFFFF);
		push_ticks(1);
		push_write(8'h00, 1'b0);
		settle();

		// Shrinking the power-on wait below the ticks already spent ends it on the next tick.
		write_timing(CFG_POWER_ON, 20'd2);
		write_timing(CFG_ENABLE_HIGH, 20'd1);
		write_timing(CFG_NIBBLE_GAP, 20'd1);
		write_timing(CFG_BYTE_GAP, 20'd1);
		push_ticks(10);
		push_write(8'hFF, 1'b1);
		push_ticks(12);
		push_write(8'hFF, 1'b1);
		push_write(8'h3C, 1'b0);
		push_ticks(4);
		push_write(8'h00, 1'b0);
		push_ticks(4);
		settle();

		// Longest timings, each cut short while its phase is running.
		write_timing(CFG_ENABLE_HIGH, 20'd255);
		write_timing(CFG_NIBBLE_GAP, 20'd65535);
		write_timing(CFG_BYTE_GAP, 20'd65535);
		push_write(8'h81, 1'b1);
		push_ticks(3);
		settle();
		write_timing(CFG_ENABLE_HIGH, 20'd1);
		push_ticks(3);
		settle();
		write_timing(CFG_NIBBLE_GAP, 20'd1);
		push_ticks(4);
		settle();
		write_timing(CFG_BYTE_GAP, 20'd1);
		push_ticks(1);
		push_write(8'h5A, 1'b0);

		run_random(1, 1, 1, 100, 40);
		run_random($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6), 150, 30);
		squeeze_now = 1'b1;
		run_random(255, 2, 3, 250, 3);
		run_random($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12), 100, 30);
		run_random($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3), 50, 50);
		settle();

		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
